FILE: rtl/core/nne_pkg.sv
// nne_pkg: field widths, request codes and control structs of the nand netlist evaluator
// no dependencies; imported by every module of the block
`default_nettype none

package nne_pkg;

    localparam int TYPE_W = 2;
    localparam int FIELD_W = 9;
    localparam int OPD_W = 8;
    localparam int RES_W = 8;

    localparam logic [TYPE_W-1:0] REQ_GATE = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_OUT  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_EVAL = 2'd2;

    typedef struct packed {
        logic valid;
        logic write;
    } t_issue_ctl;

    typedef struct packed {
        logic valid;
        logic write;
        logic value;
    } t_eval_res;

endpackage

`default_nettype wire

FILE: rtl/core/nne_gate_store.sv
// nne_gate_store: memory of the two source channels of every gate, registered read
// depends on nne_pkg for the field width
`default_nettype none

module nne_gate_store #(
    parameter int GATE_COUNT = 256,
    parameter int GW = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [GW-1:0]               i_waddr,
    input  wire logic [nne_pkg::FIELD_W-1:0] i_wsrc_a,
    input  wire logic [nne_pkg::FIELD_W-1:0] i_wsrc_b,
    input  wire logic [GW-1:0]               i_raddr,
    output logic      [nne_pkg::FIELD_W-1:0] o_src_a,
    output logic      [nne_pkg::FIELD_W-1:0] o_src_b
);
    import nne_pkg::*;

    logic [2*FIELD_W-1:0] r_mem [GATE_COUNT];
    logic [2*FIELD_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wsrc_a, i_wsrc_b};
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_src_a = r_rd[2*FIELD_W-1:FIELD_W];
    assign o_src_b = r_rd[FIELD_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/nne_eval_unit.sv
// nne_eval_unit: shared nand unit with channel value memory, input bit select and forwarding
// depends on nne_pkg for the issue and result structs
`default_nettype none

module nne_eval_unit #(
    parameter int DATA_BITS = 8,
    parameter int GATE_COUNT = 256,
    parameter int IW = 9,
    parameter int GW = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire nne_pkg::t_issue_ctl      i_ctl,
    input  wire logic [IW-1:0]            i_chan,
    input  wire logic [IW-1:0]            i_src_a,
    input  wire logic [IW-1:0]            i_src_b,
    input  wire logic [2*DATA_BITS-1:0]   i_in_bits,
    output nne_pkg::t_eval_res            o_res
);
    import nne_pkg::*;

    localparam int INPUT_CHANNELS = 2 * DATA_BITS;
    localparam int IBW = $clog2(INPUT_CHANNELS);

    logic r_mem [GATE_COUNT];

    t_issue_ctl   r_c_ctl;
    logic [IW-1:0] r_c_chan;
    logic         r_rd_a, r_rd_b;
    logic         r_mem_a, r_mem_b;
    logic         r_fix_a, r_fix_b;
    logic         r_fwd_a, r_fwd_b;
    logic         r_last;

    logic [IW-1:0] off_a, off_b, rev_a, rev_b, c_off;
    logic          rng_a, rng_b, inp_a, inp_b, fwd_a, fwd_b;
    logic          va, vb, nand_v;

    always_comb begin
        off_a = i_src_a - IW'(INPUT_CHANNELS);
        off_b = i_src_b - IW'(INPUT_CHANNELS);
        rev_a = IW'(INPUT_CHANNELS - 1) - i_src_a;
        rev_b = IW'(INPUT_CHANNELS - 1) - i_src_b;
        rng_a = i_src_a < i_chan;
        rng_b = i_src_b < i_chan;
        inp_a = i_src_a < IW'(INPUT_CHANNELS);
        inp_b = i_src_b < IW'(INPUT_CHANNELS);
        fwd_a = r_c_ctl.valid && r_c_ctl.write && (i_src_a == r_c_chan);
        fwd_b = r_c_ctl.valid && r_c_ctl.write && (i_src_b == r_c_chan);
        c_off = r_c_chan - IW'(INPUT_CHANNELS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else begin
            r_c_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_chan <= i_chan;
        r_fwd_a  <= rng_a && fwd_a;
        r_fwd_b  <= rng_b && fwd_b;
        r_mem_a  <= rng_a && !inp_a && !fwd_a;
        r_mem_b  <= rng_b && !inp_b && !fwd_b;
        r_fix_a  <= rng_a && inp_a && i_in_bits[rev_a[IBW-1:0]];
        r_fix_b  <= rng_b && inp_b && i_in_bits[rev_b[IBW-1:0]];
        r_rd_a   <= r_mem[off_a[GW-1:0]];
        r_rd_b   <= r_mem[off_b[GW-1:0]];
        if (r_c_ctl.valid && r_c_ctl.write) begin
            r_mem[c_off[GW-1:0]] <= nand_v;
            r_last <= nand_v;
        end
    end

    always_comb begin
        va = r_fwd_a ? r_last : (r_mem_a ? r_rd_a : r_fix_a);
        vb = r_fwd_b ? r_last : (r_mem_b ? r_rd_b : r_fix_b);
        nand_v = !(va && vb);
        o_res.valid = r_c_ctl.valid;
        o_res.write = r_c_ctl.write;
        o_res.value = va;
    end

endmodule

`default_nettype wire

FILE: rtl/core/nand_netlist_evaluator_top.sv
// nand netlist evaluator: writes are accepted while the sequencer is idle, also while a result waits
// evaluate: one gate and then one output slot per cycle through the shared nand unit; input
// stalled until the result is loaded, so the next evaluation waits for the previous result
// reset clears the sequencer and valid flags; gate and output map contents are not cleared
// depends on nne_pkg, nne_gate_store and nne_eval_unit
`default_nettype none

module nand_netlist_evaluator_top #(
    parameter int DATA_BITS = 8,
    parameter int GATE_COUNT = 256,
    parameter int OUTPUT_COUNT = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [nne_pkg::TYPE_W-1:0]  i_req_type,
    input  wire logic [nne_pkg::FIELD_W-1:0] i_target,
    input  wire logic [nne_pkg::FIELD_W-1:0] i_source_a,
    input  wire logic [nne_pkg::FIELD_W-1:0] i_source_b,
    input  wire logic [nne_pkg::OPD_W-1:0]   i_operand_a,
    input  wire logic [nne_pkg::OPD_W-1:0]   i_operand_b,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [nne_pkg::RES_W-1:0]   o_result
);
    import nne_pkg::*;

    localparam int INPUT_CHANNELS = 2 * DATA_BITS;
    localparam int CHANNEL_TOTAL = INPUT_CHANNELS + GATE_COUNT;
    localparam int CW = $clog2(CHANNEL_TOTAL + 1);
    localparam int IW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int GW = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
    localparam int GCW = $clog2(GATE_COUNT + 1);
    localparam int OW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
    localparam int OCW = $clog2(OUTPUT_COUNT + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GATE  = 3'd1;
    localparam logic [2:0] S_OUT   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;

    logic [2:0]           r_state, n_state;
    logic [GCW-1:0]       r_gcnt, n_gcnt;
    logic [OCW-1:0]       r_ocnt, n_ocnt;
    logic [OCW-1:0]       r_ocoll, n_ocoll;
    logic [RES_W-1:0]     r_acc, n_acc;
    logic [DATA_BITS-1:0] r_word_a, r_word_b;
    logic                 r_a_valid, n_a_valid;
    logic [IW-1:0]        r_a_chan;
    logic                 r_m_valid, n_m_valid;
    logic [FIELD_W-1:0]   r_map_ch;
    logic                 r_out_valid, n_out_valid;
    logic [RES_W-1:0]     r_result;

    logic [FIELD_W-1:0] r_omap [OUTPUT_COUNT];

    logic               in_take, out_take, load_res;
    logic [IW-1:0]      tgt_x, tgt_off;
    logic               gate_we, omap_we;
    logic [GW-1:0]      gate_raddr;
    logic [FIELD_W-1:0] st_src_a, st_src_b;
    t_issue_ctl         iss_ctl;
    logic [IW-1:0]      iss_chan, iss_src_a, iss_src_b;
    t_eval_res          res;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        tgt_x   = IW'(i_target);
        tgt_off = tgt_x - IW'(INPUT_CHANNELS);
        gate_we = in_take && (i_req_type == REQ_GATE) && (tgt_x >= IW'(INPUT_CHANNELS))
                  && (tgt_x < IW'(CHANNEL_TOTAL));
        omap_we = in_take && (i_req_type == REQ_OUT) && (i_target < FIELD_W'(OUTPUT_COUNT));
        gate_raddr = r_gcnt[GW-1:0];
    end

    nne_gate_store #(
        .GATE_COUNT(GATE_COUNT),
        .GW(GW)
    ) u_gate_store (
        .i_clk(i_clk),
        .i_we(gate_we),
        .i_waddr(tgt_off[GW-1:0]),
        .i_wsrc_a(i_source_a),
        .i_wsrc_b(i_source_b),
        .i_raddr(gate_raddr),
        .o_src_a(st_src_a),
        .o_src_b(st_src_b)
    );

    always_ff @(posedge i_clk) begin
        if (omap_we) begin
            r_omap[i_target[OW-1:0]] <= i_source_a;
        end
        r_map_ch <= r_omap[r_ocnt[OW-1:0]];
    end

    always_comb begin
        if (r_m_valid) begin
            iss_ctl.valid = 1'b1;
            iss_ctl.write = 1'b0;
            iss_chan  = IW'(CHANNEL_TOTAL);
            iss_src_a = IW'(r_map_ch);
            iss_src_b = '0;
        end else begin
            iss_ctl.valid = r_a_valid;
            iss_ctl.write = 1'b1;
            iss_chan  = r_a_chan;
            iss_src_a = IW'(st_src_a);
            iss_src_b = IW'(st_src_b);
        end
    end

    nne_eval_unit #(
        .DATA_BITS(DATA_BITS),
        .GATE_COUNT(GATE_COUNT),
        .IW(IW),
        .GW(GW)
    ) u_eval_unit (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl(iss_ctl),
        .i_chan(iss_chan),
        .i_src_a(iss_src_a),
        .i_src_b(iss_src_b),
        .i_in_bits({r_word_a, r_word_b}),
        .o_res(res)
    );

    always_comb begin
        n_state     = r_state;
        n_gcnt      = r_gcnt;
        n_ocnt      = r_ocnt;
        n_ocoll     = r_ocoll;
        n_acc       = r_acc;
        n_a_valid   = 1'b0;
        n_m_valid   = 1'b0;
        load_res    = 1'b0;
        n_out_valid = r_out_valid && !out_take;
        if (res.valid && !res.write) begin
            n_acc   = {r_acc[RES_W-2:0], res.value};
            n_ocoll = r_ocoll + OCW'(1);
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_take && (i_req_type == REQ_EVAL)) begin
                    n_state = S_GATE;
                    n_gcnt  = '0;
                    n_ocnt  = '0;
                    n_ocoll = '0;
                    n_acc   = '0;
                end
            end
            S_GATE: begin
                n_a_valid = 1'b1;
                n_gcnt    = r_gcnt + GCW'(1);
                if (r_gcnt == GCW'(GATE_COUNT - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_m_valid = 1'b1;
                n_ocnt    = r_ocnt + OCW'(1);
                if (r_ocnt == OCW'(OUTPUT_COUNT - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if ((r_ocoll == OCW'(OUTPUT_COUNT)) && (!r_out_valid || out_take)) begin
                    load_res    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gcnt      <= '0;
            r_ocnt      <= '0;
            r_ocoll     <= '0;
            r_a_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gcnt      <= n_gcnt;
            r_ocnt      <= n_ocnt;
            r_ocoll     <= n_ocoll;
            r_a_valid   <= n_a_valid;
            r_m_valid   <= n_m_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_a_chan <= IW'(INPUT_CHANNELS) + IW'(r_gcnt);
        if (in_take && (i_req_type == REQ_EVAL)) begin
            r_word_a <= DATA_BITS'(i_operand_a);
            r_word_b <= DATA_BITS'(i_operand_b);
        end
        if (load_res) begin
            r_result <= r_acc;
        end
    end

endmodule

`default_nettype wire
